// File: hdl/mffr_pkg.sv
// Shared constants and types for the motor feedback frame receiver.
package mffr_pkg;

   localparam int MOTOR_COUNT = 14;
   localparam int REC_BYTES   = 5;
   localparam int REC_W       = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam int ADDR_W      = REC_W + 1;
   localparam int MEM_DEPTH   = 2 * (1 << REC_W);
   localparam int BCNT_W      = $clog2(REC_BYTES);

   localparam logic [REC_W-1:0]  LAST_REC      = REC_W'(MOTOR_COUNT - 1);
   localparam logic [BCNT_W-1:0] LAST_REC_BYTE = BCNT_W'(REC_BYTES - 1);
   localparam logic [7:0]        HEADER_RESET  = 8'd123;

   typedef logic [8*REC_BYTES-1:0] rec_word_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      rec_word_type      data;
   } wr_port_type;

endpackage

// File: hdl/mffr_front.sv
// Front end: header hunt, XOR check and record assembly into a frame bank.
module mffr_front
   import mffr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   output wr_port_type wr_port,
   output logic        push_valid,
   output logic        push_bank,
   input  logic        push_ready,
   input  logic [1:0]  bank_free
);

   localparam logic [1:0] ST_HUNT  = 2'd0;
   localparam logic [1:0] ST_DATA  = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [7:0]        header_ff, header_in;
   logic [REC_W-1:0]  rec_ff, rec_in;
   logic [BCNT_W-1:0] bcnt_ff, bcnt_in;
   logic [7:0]        xor_ff, xor_in;
   logic [31:0]       shift_ff, shift_in;
   logic              bank_ff, bank_in;
   logic [1:0]        busy_ff, busy_in;
   logic              accept;

   always_comb begin
      case (state_ff)
         ST_HUNT:  req_ready = 1'b1;
         ST_DATA:  req_ready = !busy_ff[bank_ff];
         ST_CHECK: req_ready = push_ready;
         default:  req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      header_in    = csr_we ? csr_wdata : header_ff;
      rec_in       = rec_ff;
      bcnt_in      = bcnt_ff;
      xor_in       = xor_ff;
      shift_in     = shift_ff;
      bank_in      = bank_ff;
      push_valid   = 1'b0;
      wr_port.en   = 1'b0;
      wr_port.addr = {bank_ff, rec_ff};
      wr_port.data = {shift_ff, req_rx_byte};
      if (accept) begin
         case (state_ff)
            ST_HUNT: begin
               if (req_rx_byte == header_ff) begin
                  state_in = ST_DATA;
                  xor_in   = req_rx_byte;
                  rec_in   = '0;
                  bcnt_in  = '0;
               end
            end
            ST_DATA: begin
               xor_in   = xor_ff ^ req_rx_byte;
               shift_in = {shift_ff[23:0], req_rx_byte};
               if (bcnt_ff == LAST_REC_BYTE) begin
                  wr_port.en = 1'b1;
                  bcnt_in    = '0;
                  if (rec_ff == LAST_REC) begin
                     state_in = ST_CHECK;
                  end else begin
                     rec_in = rec_ff + 1'b1;
                  end
               end else begin
                  bcnt_in = bcnt_ff + 1'b1;
               end
            end
            ST_CHECK: begin
               state_in = ST_HUNT;
               xor_in   = '0;
               // A good frame hands its bank to the back end; a bad one is reused.
               if (xor_ff == req_rx_byte) begin
                  push_valid = 1'b1;
                  bank_in    = !bank_ff;
               end
            end
            default: state_in = ST_HUNT;
         endcase
      end
   end

   assign push_bank = bank_ff;

   always_comb begin
      busy_in = busy_ff & ~bank_free;
      if (push_valid) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_HUNT;
         header_ff <= HEADER_RESET;
         rec_ff    <= '0;
         bcnt_ff   <= '0;
         xor_ff    <= '0;
         bank_ff   <= 1'b0;
         busy_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         header_ff <= header_in;
         rec_ff    <= rec_in;
         bcnt_ff   <= bcnt_in;
         xor_ff    <= xor_in;
         bank_ff   <= bank_in;
         busy_ff   <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

endmodule

// File: hdl/mffr_queue.sv
// Two-entry queue of finished frame bank numbers between front and back end.
module mffr_queue
   import mffr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   input  logic push_bank,
   output logic push_ready,
   output logic pop_valid,
   output logic pop_bank,
   input  logic pop_ready
);

   logic [1:0] slot_ff;
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_bank   = slot_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wptr_in  = do_push ? !wptr_ff : wptr_ff;
      rptr_in  = do_pop ? !rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_bank;
      end
   end

endmodule

// File: hdl/mffr_back.sv
// Back end: record memory and result emission from one frame bank at a time.
module mffr_back
   import mffr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  wr_port_type wr_port,
   input  logic        pop_valid,
   input  logic        pop_bank,
   output logic        pop_ready,
   output logic [1:0]  bank_free,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_motor_index,
   output logic [15:0] rsp_position_raw,
   output logic [11:0] rsp_velocity_raw,
   output logic [11:0] rsp_torque_raw,
   output logic        rsp_last_record
);

   rec_word_type     mem [MEM_DEPTH];
   rec_word_type     rd_data_ff;
   logic [REC_W-1:0] rd_rec_ff;
   logic             rd_valid_ff, rd_valid_in;
   logic             active_ff, active_in;
   logic             bank_ff, bank_in;
   logic [REC_W-1:0] rec_ff, rec_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rec_word_type     out_data_ff;
   logic [REC_W-1:0] out_rec_ff;
   logic             issue, load;

   assign pop_ready = !active_ff;
   assign load      = rd_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign issue     = active_ff && (!rd_valid_ff || load);

   always_comb begin
      active_in    = active_ff;
      bank_in      = bank_ff;
      rec_in       = rec_ff;
      bank_free    = '0;
      rd_valid_in  = issue ? 1'b1 : (load ? 1'b0 : rd_valid_ff);
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      if (pop_valid && pop_ready) begin
         active_in = 1'b1;
         bank_in   = pop_bank;
         rec_in    = '0;
      end
      if (issue) begin
         // The bank is released as soon as its last record has been read.
         if (rec_ff == LAST_REC) begin
            active_in          = 1'b0;
            bank_free[bank_ff] = 1'b1;
         end else begin
            rec_in = rec_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         bank_ff      <= 1'b0;
         rec_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         bank_ff      <= bank_in;
         rec_ff       <= rec_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_port.en) begin
         mem[wr_port.addr] <= wr_port.data;
      end
      if (issue) begin
         rd_data_ff <= mem[{bank_ff, rec_ff}];
         rd_rec_ff  <= rec_ff;
      end
      if (load) begin
         out_data_ff <= rd_data_ff;
         out_rec_ff  <= rd_rec_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_motor_index  = 4'(out_rec_ff);
   assign rsp_position_raw = out_data_ff[39:24];
   assign rsp_velocity_raw = out_data_ff[23:12];
   assign rsp_torque_raw   = out_data_ff[11:0];
   assign rsp_last_record  = (out_rec_ff == LAST_REC);

   a_no_write_to_read_bank: assert property (@(posedge clock) disable iff (reset)
      wr_port.en && active_ff |-> wr_port.addr[ADDR_W-1] != bank_ff)
      else $error("front end wrote into the bank being emitted");

   a_frame_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_record |=> !rsp_valid || rsp_motor_index == 4'd0)
      else $error("new frame did not start at record zero");

   a_read_data_held: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff && !load |=> $stable(rd_data_ff) && rd_valid_ff)
      else $error("pending read data lost before it reached the output");

endmodule

// File: hdl/motor_feedback_frame_receiver.sv
// Top level of the motor feedback frame receiver: front end, bank queue and back end.
//
//   port group  direction  handshake              contents
//   req_        in         req_valid/req_ready    one received byte per word
//   rsp_        out        rsp_valid/rsp_ready    one motor record per word
//   csr_        in         csr_we (no wait)       header byte value
//
// One byte is accepted per cycle while req_ready is high. A good frame's records pass the bank
// queue, read register and output register, then leave one per cycle while rsp_ready is high.
// Record storage holds two frames; data bytes of a third frame stall until the back end has
// read the older bank. Reset returns to hunting with header 123; the record memory is never
// cleared, since every record is written before it is read.
module motor_feedback_frame_receiver
   import mffr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_motor_index,
   output logic [15:0] rsp_position_raw,
   output logic [11:0] rsp_velocity_raw,
   output logic [11:0] rsp_torque_raw,
   output logic        rsp_last_record
);

   wr_port_type wr_port;
   logic        push_valid, push_bank, push_ready;
   logic        pop_valid, pop_bank, pop_ready;
   logic [1:0]  bank_free;

   mffr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .wr_port     (wr_port),
      .push_valid  (push_valid),
      .push_bank   (push_bank),
      .push_ready  (push_ready),
      .bank_free   (bank_free)
   );

   mffr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_bank  (push_bank),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_bank   (pop_bank),
      .pop_ready  (pop_ready)
   );

   mffr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .wr_port          (wr_port),
      .pop_valid        (pop_valid),
      .pop_bank         (pop_bank),
      .pop_ready        (pop_ready),
      .bank_free        (bank_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_motor_index  (rsp_motor_index),
      .rsp_position_raw (rsp_position_raw),
      .rsp_velocity_raw (rsp_velocity_raw),
      .rsp_torque_raw   (rsp_torque_raw),
      .rsp_last_record  (rsp_last_record)
   );

endmodule

// File: dv/motor_feedback_frame_receiver_test.sv
// Testbench for the motor feedback frame receiver: header sync, XOR check and record unpacking.
`timescale 1ns / 1ps

module motor_feedback_frame_receiver_test
   import mffr_pkg::*;
();

   localparam int FRAME_LEN     = REC_BYTES * MOTOR_COUNT + 2;
   localparam int HOLD_CYCLES   = 600;
   localparam int STALL_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 40;

   // Record content patterns for one frame.
   localparam int PAT_RANDOM = 0;
   localparam int PAT_ZEROS  = 1;
   localparam int PAT_ONES   = 2;
   localparam int PAT_MIXED  = 3;
   localparam int PAT_HEADER = 4;

   // Receiver stall patterns.
   localparam int RDY_ALWAYS = 0;
   localparam int RDY_HALF   = 1;
   localparam int RDY_SPARSE = 2;
   localparam int RDY_TOGGLE = 3;

   localparam logic [7:0] MIXED_BYTES [6] = '{8'h00, 8'hFF, 8'hF0, 8'h0F, 8'h80, 8'h01};

   typedef logic [7:0] frame_type [FRAME_LEN];

   typedef struct packed {
      logic [3:0]  motor_index;
      logic [15:0] position_raw;
      logic [11:0] velocity_raw;
      logic [11:0] torque_raw;
      logic        last_record;
   } motor_record_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        csr_we      = 1'b0;
   logic [7:0]  csr_wdata   = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [3:0]  rsp_motor_index;
   logic [15:0] rsp_position_raw;
   logic [11:0] rsp_velocity_raw;
   logic [11:0] rsp_torque_raw;
   logic        rsp_last_record;
   logic        hold_start  = 1'b0;

   // Mirror of the receiver state.
   logic [7:0]       header_value = HEADER_RESET;
   logic [7:0]       frame_bytes [FRAME_LEN];
   int               frame_pos    = 0;
   logic [7:0]       frame_xor    = 8'd0;
   motor_record_type expected_records [$];

   int mismatches    = 0;
   int burst_left    = 0;
   int hold_left     = 0;
   int mode_left     = 0;
   int ready_mode    = RDY_ALWAYS;
   int idle_cycles   = 0;

   motor_feedback_frame_receiver DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_motor_index  (rsp_motor_index),
      .rsp_position_raw (rsp_position_raw),
      .rsp_velocity_raw (rsp_velocity_raw),
      .rsp_torque_raw   (rsp_torque_raw),
      .rsp_last_record  (rsp_last_record)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] wanted);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, wanted);
   endtask

   // Advances the frame tracker by one accepted byte and queues the records of a good frame.
   task automatic track_rx_byte(input logic [7:0] b);
      motor_record_type rec;
      int base;
      int r;
      if (frame_pos == 0) begin
         if (b == header_value) begin
            frame_bytes[0] = b;
            frame_xor = b;
            frame_pos = 1;
         end
      end else if (frame_pos + 1 < FRAME_LEN) begin
         frame_bytes[frame_pos] = b;
         frame_xor ^= b;
         frame_pos++;
      end else begin
         frame_pos = 0;
         if (frame_xor == b) begin
            for (r = 0; r < MOTOR_COUNT; r++) begin
               base = 1 + r * REC_BYTES;
               rec.motor_index  = 4'(r);
               rec.position_raw = {frame_bytes[base], frame_bytes[base + 1]};
               rec.velocity_raw = {frame_bytes[base + 2], frame_bytes[base + 3][7:4]};
               rec.torque_raw   = {frame_bytes[base + 3][3:0], frame_bytes[base + 4]};
               rec.last_record  = (r == MOTOR_COUNT - 1);
               expected_records = {expected_records, rec};
            end
         end
         frame_xor = 8'd0;
      end
   endtask

   // Offers one word in bursts with random gaps; valid stays high between words of a burst.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      track_rx_byte(b);
   endtask

   task automatic wait_records_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_records.size() != 0) @(posedge clock);
      // A dropped frame leaves nothing to wait for, so give the pipeline time to settle.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_header(input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      header_value = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void build_frame(input logic [7:0] hdr, input int pattern,
                                       input bit bad_check, output frame_type f);
      logic [7:0] x;
      int i;
      f[0] = hdr;
      x = hdr;
      for (i = 1; i < FRAME_LEN - 1; i++) begin
         case (pattern)
            PAT_ZEROS:  f[i] = 8'h00;
            PAT_ONES:   f[i] = 8'hFF;
            PAT_MIXED:  f[i] = MIXED_BYTES[(i + (i - 1) / REC_BYTES) % 6];
            PAT_HEADER: f[i] = $urandom_range(0, 1) ? hdr : 8'($urandom_range(0, 255));
            default:    f[i] = 8'($urandom_range(0, 255));
         endcase
         x ^= f[i];
      end
      f[FRAME_LEN - 1] = bad_check ? x ^ 8'($urandom_range(1, 255)) : x;
   endfunction

   task automatic send_frame(input int pattern, input bit bad_check);
      frame_type f;
      build_frame(header_value, pattern, bad_check, f);
      foreach (f[i]) send_byte(f[i]);
   endtask

   task automatic send_noise(input int count, input bit allow_header);
      logic [7:0] b;
      repeat (count) begin
         b = 8'($urandom_range(0, 255));
         if (!allow_header && b == header_value) b = ~b;
         send_byte(b);
      end
   endtask

   task automatic test_default_header();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_noise(4, 1'b0);
      send_frame(PAT_ZEROS, 1'b0);
   endtask

   task automatic test_bad_check();
      send_frame(PAT_MIXED, 1'b1);
   endtask

   // Records back up while the receiver holds off, until the input stalls too.
   task automatic test_backpressure();
      wait_records_drained();
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      send_frame(PAT_RANDOM, 1'b0);
      send_frame(PAT_ONES, 1'b0);
      send_frame(PAT_MIXED, 1'b0);
   endtask

   task automatic test_sender_pause();
      wait_records_drained();
   endtask

   // The new header takes effect only once the frame in progress has ended.
   task automatic test_header_register();
      frame_type f;
      int i;
      build_frame(header_value, PAT_RANDOM, 1'b0, f);
      for (i = 0; i < 20; i++) send_byte(f[i]);
      wait_records_drained();
      write_header(8'h00);
      for (i = 20; i < FRAME_LEN; i++) send_byte(f[i]);
      send_noise(3, 1'b0);
   endtask

   // Header values inside the data must not restart the frame.
   task automatic test_header_in_data();
      send_frame(PAT_HEADER, 1'b0);
   endtask

   // Receiver: a long hold-off on request, otherwise a changing stall pattern.
   always @(posedge clock) begin
      if (hold_start) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(RDY_ALWAYS, RDY_TOGGLE);
            mode_left  = $urandom_range(5, 80);
         end
         mode_left--;
         case (ready_mode)
            RDY_ALWAYS: rsp_ready <= 1'b1;
            RDY_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:    rsp_ready <= ~rsp_ready;
         endcase
      end
   end

   always @(posedge clock) begin
      motor_record_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_records.size() == 0) begin
            report_mismatch("record with none pending", rsp_position_raw, 16'd0);
         end else begin
            want = expected_records.pop_front();
            if (rsp_motor_index !== want.motor_index)
               report_mismatch("motor_index", 16'(rsp_motor_index), 16'(want.motor_index));
            if (rsp_position_raw !== want.position_raw)
               report_mismatch("position_raw", rsp_position_raw, want.position_raw);
            if (rsp_velocity_raw !== want.velocity_raw)
               report_mismatch("velocity_raw", 16'(rsp_velocity_raw), 16'(want.velocity_raw));
            if (rsp_torque_raw !== want.torque_raw)
               report_mismatch("torque_raw", 16'(rsp_torque_raw), 16'(want.torque_raw));
            if (rsp_last_record !== want.last_record)
               report_mismatch("last_record", 16'(rsp_last_record), 16'(want.last_record));
         end
      end
   end

   // Watchdog on cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_header();
      test_bad_check();
      test_backpressure();
      test_sender_pause();
      test_header_register();
      test_header_in_data();
      wait_records_drained();
      if (mismatches == 0 && expected_records.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// File: filelist.f
hdl/mffr_pkg.sv
hdl/mffr_front.sv
hdl/mffr_queue.sv
hdl/mffr_back.sv
hdl/motor_feedback_frame_receiver.sv
dv/motor_feedback_frame_receiver_test.sv
